[src/afps_pkg.sv]
// Shared types and constants for the airbrake flight phase sequencer.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package afps_pkg;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned PROD_W  = 23;

  // event kinds
  localparam logic [1:0] EV_TICK   = 2'd0;
  localparam logic [1:0] EV_ONOFF  = 2'd1;
  localparam logic [1:0] EV_ANALOG = 2'd2;

  // actuator ids
  localparam logic [2:0] ACT_CHARGER  = 3'd0;
  localparam logic [2:0] ACT_INJECTOR = 3'd1;
  localparam logic [2:0] ACT_SERVO    = 3'd2;
  localparam logic [2:0] ACT_DEBUG    = 3'd3;

  // flight phases
  localparam logic [1:0] PH_PRE     = 2'd0;
  localparam logic [1:0] PH_BOOST   = 2'd1;
  localparam logic [1:0] PH_COAST   = 2'd2;
  localparam logic [1:0] PH_DESCENT = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_BOOST_LEN = 3'd0;
  localparam logic [2:0] CFG_COAST_LEN = 3'd1;
  localparam logic [2:0] CFG_MOTOR_ACT = 3'd2;
  localparam logic [2:0] CFG_MIN_PULSE = 3'd3;
  localparam logic [2:0] CFG_MAX_PULSE = 3'd4;

  localparam logic [31:0] BOOST_LEN_RST = 32'd1000;
  localparam logic [31:0] COAST_LEN_RST = 32'd2000000;
  localparam logic [15:0] MOTOR_ACT_RST = 16'd500;
  localparam logic [15:0] MIN_PULSE_RST = 16'd500;
  localparam logic [15:0] MAX_PULSE_RST = 16'd2500;
  localparam logic [32:0] COAST_END_RST = 33'd2001000;

  localparam logic [7:0]       CMD_ON      = 8'd1;
  localparam logic [7:0]       CMD_OFF     = 8'd0;
  localparam logic [7:0]       CMD_INVALID = 8'd255;
  localparam logic [7:0]       PCT_MAX8    = 8'd100;
  localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;

  // floor(p / 100) = (p * RECIP_100) >> RECIP_SHIFT, exact for p < 2**23
  localparam logic [23:0]  RECIP_100   = 24'd10737419;
  localparam int unsigned  RECIP_SHIFT = 30;

  typedef struct packed {
    logic [1:0]       phase;
    logic             servo_pwr;
    logic [PCT_W-1:0] ext;
    logic             charger_on;
    logic             debug_armed;
  } status_t;

endpackage

`default_nettype wire

[src/afps_state.sv]
// Flight phase state and event decode: applies one event per load strobe.
// The state registers double as the pipeline stage after the input register. Uses afps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afps_state #(
  parameter int unsigned TIMER_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic [1:0]           action,
  input  wire logic [2:0]           actuator,
  input  wire logic [7:0]           cmd_value,
  input  wire logic [31:0]          boost_len,
  input  wire logic [32:0]          coast_end,
  input  wire logic [15:0]          motor_act,
  output afps_pkg::status_t         status
);

  logic [TIMER_WIDTH-1:0]       since_inj_r, since_inj_nxt;
  logic [TIMER_WIDTH-1:0]       since_act_r, since_act_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic                         motor_r, motor_nxt;
  logic [afps_pkg::PCT_W-1:0]   ext_r, ext_nxt;
  logic                         dbg_en_r, dbg_en_nxt;
  logic [afps_pkg::PCT_W-1:0]   dbg_ext_r, dbg_ext_nxt;
  logic                         chg_r, chg_nxt;
  logic [afps_pkg::PCT_W-1:0]   pct;

  assign pct = (cmd_value > afps_pkg::PCT_MAX8) ? afps_pkg::PCT_MAX
                                                : cmd_value[afps_pkg::PCT_W-1:0];

  always_comb begin
    since_inj_nxt = since_inj_r;
    since_act_nxt = since_act_r;
    phase_nxt     = phase_r;
    motor_nxt     = motor_r;
    ext_nxt       = ext_r;
    dbg_en_nxt    = dbg_en_r;
    dbg_ext_nxt   = dbg_ext_r;
    chg_nxt       = chg_r;
    case (action)
      afps_pkg::EV_TICK: begin
        since_inj_nxt = since_inj_r + 1'b1;
        since_act_nxt = since_act_r + 1'b1;
        if (phase_nxt == afps_pkg::PH_BOOST &&
            33'(since_inj_nxt) > 33'(boost_len)) begin
          phase_nxt = afps_pkg::PH_COAST;
          motor_nxt = 1'b1;
        end
        if (phase_nxt == afps_pkg::PH_COAST && 33'(since_inj_nxt) > coast_end) begin
          phase_nxt     = afps_pkg::PH_DESCENT;
          motor_nxt     = 1'b1;
          ext_nxt       = '0;
          since_act_nxt = '0;
        end
        if ((phase_nxt == afps_pkg::PH_PRE || phase_nxt == afps_pkg::PH_DESCENT) &&
            33'(since_act_nxt) > 33'(motor_act)) begin
          motor_nxt = 1'b0;
          ext_nxt   = '0;
        end
      end
      afps_pkg::EV_ONOFF: begin
        if (actuator == afps_pkg::ACT_CHARGER) begin
          if (cmd_value == afps_pkg::CMD_ON) begin
            chg_nxt = 1'b1;
          end else if (cmd_value == afps_pkg::CMD_OFF) begin
            chg_nxt = 1'b0;
          end
        end else if (actuator == afps_pkg::ACT_INJECTOR &&
                     cmd_value == afps_pkg::CMD_ON) begin
          since_inj_nxt = '0;
          phase_nxt     = afps_pkg::PH_BOOST;
        end
      end
      afps_pkg::EV_ANALOG: begin
        if (cmd_value != afps_pkg::CMD_INVALID) begin
          if (actuator == afps_pkg::ACT_SERVO) begin
            if (phase_r == afps_pkg::PH_COAST ||
                (dbg_en_r && dbg_ext_r == pct && phase_r == afps_pkg::PH_PRE)) begin
              since_act_nxt = '0;
              ext_nxt       = pct;
              motor_nxt     = 1'b1;
            end
          end else if (actuator == afps_pkg::ACT_DEBUG) begin
            dbg_ext_nxt = pct;
            dbg_en_nxt  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_inj_r <= '0;
      since_act_r <= '0;
      phase_r     <= afps_pkg::PH_PRE;
      motor_r     <= 1'b0;
      ext_r       <= '0;
      dbg_en_r    <= 1'b0;
      dbg_ext_r   <= '0;
      chg_r       <= 1'b0;
    end else if (load) begin
      since_inj_r <= since_inj_nxt;
      since_act_r <= since_act_nxt;
      phase_r     <= phase_nxt;
      motor_r     <= motor_nxt;
      ext_r       <= ext_nxt;
      dbg_en_r    <= dbg_en_nxt;
      dbg_ext_r   <= dbg_ext_nxt;
      chg_r       <= chg_nxt;
    end
  end

  assign status.phase       = phase_r;
  assign status.servo_pwr   = motor_r;
  assign status.ext         = ext_r;
  assign status.charger_on  = chg_r;
  assign status.debug_armed = dbg_en_r;

endmodule

`default_nettype wire

[src/afps_pulse.sv]
// Servo pulse width pipeline: extension times span, then divide by 100
// via reciprocal multiply; min_pulse +/- it into result reg. Uses afps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afps_pulse (
  input  wire logic                  clk,
  input  wire logic                  load_mul,
  input  wire logic                  load_out,
  input  wire afps_pkg::status_t     status_in,
  input  wire logic [15:0]           min_pulse,
  input  wire logic [15:0]           max_pulse,
  output afps_pkg::status_t          status_out,
  output logic [15:0]                pulse_out
);

  afps_pkg::status_t                  mul_status_r;
  logic [afps_pkg::PROD_W-1:0]        prod_r;
  afps_pkg::status_t                  out_status_r;
  logic [15:0]                        pulse_r;
  logic                               neg;
  logic [15:0]                        span;
  logic [46:0]                        scaled;
  logic [15:0]                        quot;

  assign neg  = max_pulse < min_pulse;
  assign span = neg ? (min_pulse - max_pulse) : (max_pulse - min_pulse);

  always_ff @(posedge clk) begin
    if (load_mul) begin
      mul_status_r <= status_in;
      prod_r       <= afps_pkg::PROD_W'(status_in.ext) * afps_pkg::PROD_W'(span);
    end
  end

  assign scaled = 47'(prod_r) * 47'(afps_pkg::RECIP_100);
  assign quot   = scaled[afps_pkg::RECIP_SHIFT +: 16];

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= mul_status_r;
      pulse_r      <= neg ? (min_pulse - quot) : (min_pulse + quot);
    end
  end

  assign status_out = out_status_r;
  assign pulse_out  = pulse_r;

endmodule

`default_nettype wire

[src/airbrake_flight_phase_sequencer.sv]
// Airbrake flight phase sequencer, top level: ports, config registers, flow control.
// Stages: input register, phase state registers, product register, result register.
// Throughput: one request per cycle; a stalled result holds the pipe back stage by stage.
// Reset (rst_n, synchronous): phase pre-flight, timers and flags zero, config defaults.
// Depends on afps_pkg, afps_state and afps_pulse.
`timescale 1ns / 1ps
`default_nettype none

module airbrake_flight_phase_sequencer #(
  parameter int unsigned TIMER_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // actuator[2:0], cmd_value[10:3], zero[15:11]
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // phase[1:0], servo_pwr[2], extension_pct[9:3],
                                       // pulse_width_us[25:10], charger_on[26],
                                       // debug_armed[27], zero[31:28]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] boost_len_r;
  logic [31:0] coast_len_r;
  logic [15:0] motor_act_r;
  logic [15:0] min_pulse_r;
  logic [15:0] max_pulse_r;
  logic [32:0] coast_end_r;

  logic        in_vld_r;
  logic [1:0]  action_r;
  logic [2:0]  actuator_r;
  logic [7:0]  cmd_value_r;
  logic        st_vld_r, mul_vld_r, out_vld_r;
  logic        ld_out, ld_mul, ld_st, in_acc;

  afps_pkg::status_t st_status;
  afps_pkg::status_t out_status;
  logic [15:0]       out_pulse;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boost_len_r <= afps_pkg::BOOST_LEN_RST;
      coast_len_r <= afps_pkg::COAST_LEN_RST;
      motor_act_r <= afps_pkg::MOTOR_ACT_RST;
      min_pulse_r <= afps_pkg::MIN_PULSE_RST;
      max_pulse_r <= afps_pkg::MAX_PULSE_RST;
      coast_end_r <= afps_pkg::COAST_END_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          afps_pkg::CFG_BOOST_LEN: boost_len_r <= cfg_wdata;
          afps_pkg::CFG_COAST_LEN: coast_len_r <= cfg_wdata;
          afps_pkg::CFG_MOTOR_ACT: motor_act_r <= cfg_wdata[15:0];
          afps_pkg::CFG_MIN_PULSE: min_pulse_r <= cfg_wdata[15:0];
          afps_pkg::CFG_MAX_PULSE: max_pulse_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      coast_end_r <= 33'(boost_len_r) + 33'(coast_len_r);
    end
  end

  // advance each stage when the next one is empty or moving on
  assign ld_out    = mul_vld_r && (!out_vld_r || out_tready);
  assign ld_mul    = st_vld_r && (!mul_vld_r || ld_out);
  assign ld_st     = in_vld_r && (!st_vld_r || ld_mul);
  assign in_tready = !in_vld_r || ld_st;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      st_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_acc || (in_vld_r && !ld_st);
      st_vld_r  <= ld_st || (st_vld_r && !ld_mul);
      mul_vld_r <= ld_mul || (mul_vld_r && !ld_out);
      out_vld_r <= ld_out || (out_vld_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r    <= in_tuser;
      actuator_r  <= in_tdata[2:0];
      cmd_value_r <= in_tdata[10:3];
    end
  end

  afps_state #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ld_st),
    .action    (action_r),
    .actuator  (actuator_r),
    .cmd_value (cmd_value_r),
    .boost_len (boost_len_r),
    .coast_end (coast_end_r),
    .motor_act (motor_act_r),
    .status    (st_status)
  );

  afps_pulse u_pulse (
    .clk        (clk),
    .load_mul   (ld_mul),
    .load_out   (ld_out),
    .status_in  (st_status),
    .min_pulse  (min_pulse_r),
    .max_pulse  (max_pulse_r),
    .status_out (out_status),
    .pulse_out  (out_pulse)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_status.debug_armed, out_status.charger_on, out_pulse,
                       out_status.ext, out_status.servo_pwr, out_status.phase};

endmodule

`default_nettype wire

[tb/tb_airbrake_flight_phase_sequencer.sv]
// Self-checking testbench for airbrake_flight_phase_sequencer: stream driver, monitor and
// a cycle-free model of the flight phase logic that predicts one status word per request.
// Depends on afps_pkg and the block's RTL; nothing else.
`timescale 1ns / 1ps

module tb_airbrake_flight_phase_sequencer;

  localparam logic [1:0] EV_NONE   = 2'd3;
  localparam logic [2:0] ACT_OTHER = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] actuator;
    logic [7:0] value;
  } flight_cmd_t;

  typedef struct {
    logic [1:0]  phase;
    logic        servo_pwr;
    logic [6:0]  ext;
    logic [15:0] pulse;
    logic        charger_on;
    logic        armed;
  } flight_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // predictor configuration shadow
  logic [31:0] boost_ms      = afps_pkg::BOOST_LEN_RST;
  logic [31:0] coast_ms      = afps_pkg::COAST_LEN_RST;
  logic [15:0] motor_hold_ms = afps_pkg::MOTOR_ACT_RST;
  logic [15:0] pulse_lo_us   = afps_pkg::MIN_PULSE_RST;
  logic [15:0] pulse_hi_us   = afps_pkg::MAX_PULSE_RST;

  // predictor state
  logic [1:0]  fl_phase  = afps_pkg::PH_PRE;
  logic [31:0] inj_ms    = '0;
  logic [31:0] act_ms    = '0;
  logic        motor_pwr = 1'b0;
  logic [6:0]  ext_pct   = '0;
  logic        dbg_armed = 1'b0;
  logic [6:0]  dbg_pct   = '0;
  logic        chg_on    = 1'b0;

  flight_cmd_t    cmd_queue[$];
  flight_status_t status_fifo[$];

  logic        in_taken = 1'b0;
  int unsigned taken_count = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  airbrake_flight_phase_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [15:0] pulse_for(input logic [6:0] e);
    int unsigned lo;
    int unsigned hi;
    int unsigned ex;
    lo = pulse_lo_us;
    hi = pulse_hi_us;
    ex = e;
    if (hi >= lo) return 16'(lo + (ex * (hi - lo)) / 100);
    return 16'(lo - (ex * (lo - hi)) / 100);
  endfunction

  task automatic apply_event(input logic [1:0] kind, input logic [2:0] act,
                             input logic [7:0] val, output flight_status_t st);
    logic [32:0] coast_end;
    logic [7:0]  pct;
    coast_end = {1'b0, boost_ms} + {1'b0, coast_ms};
    pct = (val > afps_pkg::PCT_MAX8) ? afps_pkg::PCT_MAX8 : val;
    case (kind)
      afps_pkg::EV_TICK: begin
        inj_ms = inj_ms + 32'd1;
        act_ms = act_ms + 32'd1;
        if (fl_phase == afps_pkg::PH_BOOST && inj_ms > boost_ms) begin
          fl_phase = afps_pkg::PH_COAST;
          motor_pwr = 1'b1;
        end
        if (fl_phase == afps_pkg::PH_COAST && {1'b0, inj_ms} > coast_end) begin
          fl_phase = afps_pkg::PH_DESCENT;
          motor_pwr = 1'b1;
          ext_pct = '0;
          act_ms = '0;
        end
        if ((fl_phase == afps_pkg::PH_PRE || fl_phase == afps_pkg::PH_DESCENT) &&
            act_ms > {16'd0, motor_hold_ms}) begin
          motor_pwr = 1'b0;
          ext_pct = '0;
        end
      end
      afps_pkg::EV_ONOFF: begin
        if (act == afps_pkg::ACT_CHARGER) begin
          if (val == afps_pkg::CMD_ON) chg_on = 1'b1;
          else if (val == afps_pkg::CMD_OFF) chg_on = 1'b0;
        end else if (act == afps_pkg::ACT_INJECTOR && val == afps_pkg::CMD_ON) begin
          inj_ms = '0;
          fl_phase = afps_pkg::PH_BOOST;
        end
      end
      afps_pkg::EV_ANALOG: begin
        if (val != afps_pkg::CMD_INVALID) begin
          if (act == afps_pkg::ACT_SERVO) begin
            if (fl_phase == afps_pkg::PH_COAST ||
                (dbg_armed && dbg_pct == pct[6:0] && fl_phase == afps_pkg::PH_PRE)) begin
              act_ms = '0;
              ext_pct = pct[6:0];
              motor_pwr = 1'b1;
            end
          end else if (act == afps_pkg::ACT_DEBUG) begin
            dbg_pct = pct[6:0];
            dbg_armed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    st.phase = fl_phase;
    st.servo_pwr = motor_pwr;
    st.ext = ext_pct;
    st.pulse = pulse_for(ext_pct);
    st.charger_on = chg_on;
    st.armed = dbg_armed;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // monitor and request capture
  always @(posedge clk) begin
    flight_status_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (status_fifo.size() == 0) begin
          report_mismatch("unexpected status", out_tdata, 32'd0);
        end else begin
          want = status_fifo.pop_front();
          if (out_tdata[1:0] != want.phase)
            report_mismatch("phase", 32'(out_tdata[1:0]), 32'(want.phase));
          if (out_tdata[2] != want.servo_pwr)
            report_mismatch("servo_pwr", 32'(out_tdata[2]), 32'(want.servo_pwr));
          if (out_tdata[9:3] != want.ext)
            report_mismatch("extension_pct", 32'(out_tdata[9:3]), 32'(want.ext));
          if (out_tdata[25:10] != want.pulse)
            report_mismatch("pulse_width_us", 32'(out_tdata[25:10]), 32'(want.pulse));
          if (out_tdata[26] != want.charger_on)
            report_mismatch("charger_on", 32'(out_tdata[26]), 32'(want.charger_on));
          if (out_tdata[27] != want.armed)
            report_mismatch("debug_armed", 32'(out_tdata[27]), 32'(want.armed));
          if (out_tdata[31:28] != 4'd0)
            report_mismatch("padding", 32'(out_tdata[31:28]), 32'd0);
        end
      end
      if (in_tvalid && in_tready) begin
        apply_event(in_tuser, in_tdata[2:0], in_tdata[10:3], want);
        status_fifo.push_back(want);
        taken_count++;
        in_taken = 1'b1;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    flight_cmd_t c;
    if (!in_tvalid || in_taken) begin
      if (send_gap != 0 || cmd_queue.size() == 0) begin
        if (send_gap != 0) send_gap--;
        in_tvalid <= 1'b0;
      end else begin
        c = cmd_queue.pop_front();
        in_tuser  <= c.kind;
        in_tdata  <= {5'd0, c.value, c.actuator};
        in_tvalid <= 1'b1;
        send_gap = next_gap(tx_calm);
      end
    end
  end

  // status receiver; one long hold-off to back the pipe up into the input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && taken_count >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = next_gap(rx_calm);
    end
  end

  task automatic push_cmd(input logic [1:0] kind, input logic [2:0] act, input logic [7:0] val);
    flight_cmd_t c;
    c.kind = kind;
    c.actuator = act;
    c.value = val;
    cmd_queue.push_back(c);
  endtask

  function automatic logic [7:0] pick_pct();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return 8'd0;
        1: return 8'd25;
        2: return 8'd50;
        default: return 8'd100;
      endcase
    end
    if (r < 85) return 8'($urandom_range(0, 100));
    if (r < 95) return 8'($urandom_range(101, 254));
    return afps_pkg::CMD_INVALID;
  endfunction

  task automatic push_random(input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 50)
        push_cmd(afps_pkg::EV_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      else if (r < 56)
        push_cmd(afps_pkg::EV_ONOFF, afps_pkg::ACT_INJECTOR, afps_pkg::CMD_ON);
      else if (r < 74)
        push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_SERVO, pick_pct());
      else if (r < 80)
        push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_DEBUG, pick_pct());
      else if (r < 87)
        push_cmd(afps_pkg::EV_ONOFF, afps_pkg::ACT_CHARGER,
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 1)));
      else
        push_cmd(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_tvalid || status_fifo.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    case (idx)
      afps_pkg::CFG_BOOST_LEN: boost_ms = data;
      afps_pkg::CFG_COAST_LEN: coast_ms = data;
      afps_pkg::CFG_MOTOR_ACT: motor_hold_ms = data[15:0];
      afps_pkg::CFG_MIN_PULSE: pulse_lo_us = data[15:0];
      afps_pkg::CFG_MAX_PULSE: pulse_hi_us = data[15:0];
      default: ;
    endcase
  endtask

  // upper bits of the 16-bit registers carry junk that must be dropped
  task automatic load_settings(input logic [31:0] boost, input logic [31:0] coast,
                               input logic [15:0] hold, input logic [15:0] lo,
                               input logic [15:0] hi);
    write_reg(afps_pkg::CFG_BOOST_LEN, boost);
    write_reg(afps_pkg::CFG_COAST_LEN, coast);
    write_reg(afps_pkg::CFG_MOTOR_ACT, {16'($urandom), hold});
    write_reg(afps_pkg::CFG_MIN_PULSE, {16'($urandom), lo});
    write_reg(afps_pkg::CFG_MAX_PULSE, {16'($urandom), hi});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pre-flight debug path, clamping, invalid values, ignored actuators, injector restart
    push_cmd(afps_pkg::EV_TICK,   afps_pkg::ACT_CHARGER,  8'd0);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_SERVO,    8'd50);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_DEBUG,    8'd200);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_SERVO,    8'd100);
    push_cmd(afps_pkg::EV_TICK,   3'd7,                   8'd255);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_SERVO,    afps_pkg::CMD_INVALID);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_DEBUG,    afps_pkg::CMD_INVALID);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_DEBUG,    8'd0);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_SERVO,    8'd0);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_CHARGER,  afps_pkg::CMD_ON);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_CHARGER,  8'd2);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_CHARGER,  afps_pkg::CMD_OFF);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_CHARGER,  8'd255);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_INJECTOR, afps_pkg::CMD_OFF);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_SERVO,    afps_pkg::CMD_ON);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_DEBUG,    afps_pkg::CMD_ON);
    push_cmd(afps_pkg::EV_ONOFF,  3'd7,                   afps_pkg::CMD_ON);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_CHARGER,  8'd50);
    push_cmd(afps_pkg::EV_ANALOG, ACT_OTHER,              8'd50);
    push_cmd(EV_NONE,             3'd7,                   8'd255);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_INJECTOR, 8'd1);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_INJECTOR, afps_pkg::CMD_ON);
    push_cmd(afps_pkg::EV_TICK,   afps_pkg::ACT_CHARGER,  8'd0);
    push_cmd(afps_pkg::EV_ANALOG, afps_pkg::ACT_SERVO,    8'd30);
    push_cmd(afps_pkg::EV_ONOFF,  afps_pkg::ACT_INJECTOR, afps_pkg::CMD_ON);
    wait_idle();

    // zero limits: boost through coast into descent on one tick
    load_settings(32'd0, 32'd0, 16'd0, 16'd0, 16'hFFFF);
    push_random(160);
    wait_idle();
    load_settings(32'd5, 32'd20, 16'd10, 16'd500, 16'd2500);
    push_random(160);
    wait_idle();
    // maximum limits, inverted pulse span
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    push_random(160);
    wait_idle();
    // coast end beyond 32 bits, flat pulse span
    load_settings(32'd3, 32'hFFFF_FFFF, 16'd4, 16'd1000, 16'd1000);
    push_random(160);
    wait_idle();
    repeat (4) begin
      load_settings($urandom_range(0, 30), $urandom_range(0, 60), 16'($urandom_range(0, 40)),
                    16'($urandom), 16'($urandom));
      push_random(160);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (status_fifo.size() != 0)
      report_mismatch("statuses never seen", 32'(status_fifo.size()), 32'd0);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
src/afps_pkg.sv
src/afps_state.sv
src/afps_pulse.sv
src/airbrake_flight_phase_sequencer.sv
tb/tb_airbrake_flight_phase_sequencer.sv
